>>> rtl/cpu_range_list_counter_top_macros.svh
// Assertion macros shared by the checker of cpu_range_list_counter_top.
// Each macro expands to one labeled concurrent assertion clocked on clk, reset by arst_n.
`ifndef CPU_RANGE_LIST_COUNTER_TOP_MACROS_SVH
`define CPU_RANGE_LIST_COUNTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRLC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/crlc_pkg.sv
// Package of the CPU range list counter: parse phase type, character codes, control struct.
// Used by crlc_parse, crlc_finish and the top level; depends on nothing.
package crlc_pkg;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_FIRST = 3'd1,
		PH_DASH  = 3'd2,
		PH_LAST  = 3'd3,
		PH_COMMA = 3'd4
	} phase_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	typedef struct packed {
		phase_t phase;
		logic   err;
	} ctrl_t;

endpackage

>>> rtl/crlc_span_add.sv
// Adds the members of an inclusive range to a count, saturating at the count's maximum.
// Flags a reversed range. Pure combinational; used by crlc_parse and crlc_finish.
module crlc_span_add #(
	parameter int NUM_WIDTH   = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic [NUM_WIDTH-1:0]   first,
	input  logic [NUM_WIDTH-1:0]   last_value,
	input  logic [COUNT_WIDTH-1:0] count_in,
	output logic [COUNT_WIDTH-1:0] count_out,
	output logic                   reversed
);

	localparam int SW = ((NUM_WIDTH > COUNT_WIDTH) ? NUM_WIDTH : COUNT_WIDTH) + 1;

	logic [NUM_WIDTH-1:0] span;
	logic [SW-1:0]        total;

	assign reversed  = last_value < first;
	assign span      = last_value - first;
	assign total     = SW'(count_in) + SW'(span) + SW'(1);
	assign count_out = (|total[SW-1:COUNT_WIDTH]) ? '1 : total[COUNT_WIDTH-1:0];

endmodule

>>> rtl/crlc_parse.sv
// Input register, list parser state and the snapshot register that hands a closed list on.
// Depends on crlc_pkg and crlc_span_add.
module crlc_parse #(
	parameter int NUM_WIDTH   = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             character,
	input  logic                   has_character,
	input  logic                   last,
	output logic                   snap_valid_s2,
	output crlc_pkg::ctrl_t        snap_ctrl_s2,
	output logic [NUM_WIDTH-1:0]   snap_number_s2,
	output logic [NUM_WIDTH-1:0]   snap_start_s2,
	output logic [COUNT_WIDTH-1:0] snap_count_s2,
	input  logic                   snap_ready
);

	localparam int AW = NUM_WIDTH + 4;

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   has_s1;
	logic                   last_s1;

	crlc_pkg::phase_t       phase_q;
	crlc_pkg::phase_t       phase_d;
	logic [NUM_WIDTH-1:0]   num_q;
	logic [NUM_WIDTH-1:0]   num_d;
	logic [NUM_WIDTH-1:0]   start_q;
	logic [NUM_WIDTH-1:0]   start_d;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   err_q;
	logic                   err_d;

	logic                   s2_free;
	logic                   adv1;
	logic                   take;
	logic                   is_digit;
	logic                   is_dash;
	logic                   is_comma;
	logic [3:0]             dval;
	logic [AW-1:0]          acc;
	logic                   ovf;
	logic [NUM_WIDTH-1:0]   close_first;
	logic [COUNT_WIDTH-1:0] close_sum;
	logic                   close_rev;

	assign s2_free  = !snap_valid_s2 || snap_ready;
	assign adv1     = valid_s1 && (!last_s1 || s2_free);
	assign in_stall = valid_s1 && !adv1;

	assign take     = has_s1 && !err_q;
	assign is_digit = (char_s1 >= crlc_pkg::CH_ZERO) && (char_s1 <= crlc_pkg::CH_NINE);
	assign is_dash  = char_s1 == crlc_pkg::CH_DASH;
	assign is_comma = char_s1 == crlc_pkg::CH_COMMA;
	assign dval     = char_s1[3:0];
	assign acc      = (AW'(num_q) << 3) + (AW'(num_q) << 1) + AW'(dval);
	assign ovf      = |acc[AW-1:NUM_WIDTH];

	assign close_first = (phase_q == crlc_pkg::PH_LAST) ? start_q : num_q;

	crlc_span_add #(
		.NUM_WIDTH  (NUM_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_close (
		.first     (close_first),
		.last_value(num_q),
		.count_in  (count_q),
		.count_out (close_sum),
		.reversed  (close_rev)
	);

	always_comb begin
		phase_d = phase_q;
		if (take) begin
			unique case (phase_q)
				crlc_pkg::PH_START, crlc_pkg::PH_COMMA: begin
					if (is_digit) phase_d = crlc_pkg::PH_FIRST;
				end
				crlc_pkg::PH_DASH: begin
					if (is_digit) phase_d = crlc_pkg::PH_LAST;
				end
				crlc_pkg::PH_FIRST: begin
					if (is_dash) phase_d = crlc_pkg::PH_DASH;
					else if (is_comma) phase_d = crlc_pkg::PH_COMMA;
				end
				crlc_pkg::PH_LAST: begin
					if (is_comma) phase_d = crlc_pkg::PH_COMMA;
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_comb begin
		num_d   = num_q;
		start_d = start_q;
		count_d = count_q;
		err_d   = err_q;
		if (take) begin
			unique case (phase_q)
				crlc_pkg::PH_START, crlc_pkg::PH_COMMA, crlc_pkg::PH_DASH: begin
					if (is_digit) num_d = NUM_WIDTH'(dval);
					else err_d = 1'b1;
				end
				crlc_pkg::PH_FIRST: begin
					priority if (is_digit) begin
						if (ovf) err_d = 1'b1;
						else num_d = acc[NUM_WIDTH-1:0];
					end else if (is_dash) begin
						start_d = num_q;
						num_d   = '0;
					end else if (is_comma) begin
						count_d = close_sum;
						num_d   = '0;
					end else begin
						err_d = 1'b1;
					end
				end
				crlc_pkg::PH_LAST: begin
					priority if (is_digit) begin
						if (ovf) err_d = 1'b1;
						else num_d = acc[NUM_WIDTH-1:0];
					end else if (is_comma) begin
						if (close_rev) err_d = 1'b1;
						else count_d = close_sum;
						num_d = '0;
					end else begin
						err_d = 1'b1;
					end
				end
				default: err_d = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
			has_s1  <= has_character;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= crlc_pkg::PH_START;
			num_q   <= '0;
			start_q <= '0;
			count_q <= '0;
			err_q   <= 1'b0;
		end else if (adv1) begin
			if (last_s1) begin
				phase_q <= crlc_pkg::PH_START;
				num_q   <= '0;
				start_q <= '0;
				count_q <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				num_q   <= num_d;
				start_q <= start_d;
				count_q <= count_d;
				err_q   <= err_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (s2_free) begin
			snap_valid_s2 <= adv1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && last_s1) begin
			snap_ctrl_s2.phase <= phase_d;
			snap_ctrl_s2.err   <= err_d;
			snap_number_s2     <= num_d;
			snap_start_s2      <= start_d;
			snap_count_s2      <= count_d;
		end
	end

endmodule

>>> rtl/crlc_finish.sv
// Closes the last field of a finished list and holds the result in the output register.
// Depends on crlc_pkg and crlc_span_add.
module crlc_finish #(
	parameter int NUM_WIDTH   = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   snap_valid_s2,
	input  crlc_pkg::ctrl_t        snap_ctrl_s2,
	input  logic [NUM_WIDTH-1:0]   snap_number_s2,
	input  logic [NUM_WIDTH-1:0]   snap_start_s2,
	input  logic [COUNT_WIDTH-1:0] snap_count_s2,
	output logic                   snap_ready,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COUNT_WIDTH-1:0] cpu_count,
	output logic                   malformed
);

	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   malformed_q;
	logic [NUM_WIDTH-1:0]   close_first;
	logic [COUNT_WIDTH-1:0] close_sum;
	logic                   close_rev;
	logic [COUNT_WIDTH-1:0] count_f;
	logic                   err_f;

	assign snap_ready = !out_valid_q || !out_stall;
	assign close_first = (snap_ctrl_s2.phase == crlc_pkg::PH_LAST) ? snap_start_s2
		: snap_number_s2;

	crlc_span_add #(
		.NUM_WIDTH  (NUM_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_close (
		.first     (close_first),
		.last_value(snap_number_s2),
		.count_in  (snap_count_s2),
		.count_out (close_sum),
		.reversed  (close_rev)
	);

	always_comb begin
		count_f = snap_count_s2;
		err_f   = snap_ctrl_s2.err;
		if (!snap_ctrl_s2.err) begin
			unique case (snap_ctrl_s2.phase)
				crlc_pkg::PH_START: count_f = snap_count_s2;
				crlc_pkg::PH_FIRST, crlc_pkg::PH_LAST: begin
					if (close_rev) err_f = 1'b1;
					else count_f = close_sum;
				end
				default: err_f = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_ready) begin
			out_valid_q <= snap_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid_s2 && snap_ready) begin
			count_q     <= err_f ? '0 : count_f;
			malformed_q <= err_f;
		end
	end

	assign out_valid = out_valid_q;
	assign cpu_count = count_q;
	assign malformed = malformed_q;

endmodule

>>> rtl/cpu_range_list_counter_top.sv
// Top level of the CPU range list counter: counts the members of a list such as "0-3,8,10-11".
// Instantiates crlc_parse and crlc_finish; depends on crlc_pkg.
//
// The input channel carries one character of the list per request, with has_character
// telling whether the byte is real and last closing the list. The output channel carries
// one result per list: cpu_count, the number of members, and malformed, set when the list
// broke the syntax or range rules, in which case cpu_count is zero. An empty list gives
// zero and is not malformed. The count saturates at its maximum.
// A request is taken in every cycle while the output is not stalled, so the block runs
// at one character per clock. A result appears on out_valid once the request that carried
// last has passed the input register and parser, then the snapshot register, then the
// closing logic and output register.
// While the receiver stalls, the result holds, and requests keep being taken until a
// third finished list has nowhere to go; then in_stall rises.
// Reset clears the parser to the start of a list and drops every pending result.
module cpu_range_list_counter_top #(
	parameter int NUM_WIDTH   = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             character,
	input  logic                   has_character,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COUNT_WIDTH-1:0] cpu_count,
	output logic                   malformed
);

	logic                   snap_valid_s2;
	crlc_pkg::ctrl_t        snap_ctrl_s2;
	logic [NUM_WIDTH-1:0]   snap_number_s2;
	logic [NUM_WIDTH-1:0]   snap_start_s2;
	logic [COUNT_WIDTH-1:0] snap_count_s2;
	logic                   snap_ready;

	crlc_parse #(
		.NUM_WIDTH  (NUM_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.character     (character),
		.has_character (has_character),
		.last          (last),
		.snap_valid_s2 (snap_valid_s2),
		.snap_ctrl_s2  (snap_ctrl_s2),
		.snap_number_s2(snap_number_s2),
		.snap_start_s2 (snap_start_s2),
		.snap_count_s2 (snap_count_s2),
		.snap_ready    (snap_ready)
	);

	crlc_finish #(
		.NUM_WIDTH  (NUM_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_finish (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid_s2 (snap_valid_s2),
		.snap_ctrl_s2  (snap_ctrl_s2),
		.snap_number_s2(snap_number_s2),
		.snap_start_s2 (snap_start_s2),
		.snap_count_s2 (snap_count_s2),
		.snap_ready    (snap_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cpu_count     (cpu_count),
		.malformed     (malformed)
	);

endmodule

>>> rtl/crlc_checker.sv
// Port-level checker for cpu_range_list_counter_top and the bind that attaches it.
// Depends on cpu_range_list_counter_top_macros.svh.
`include "cpu_range_list_counter_top_macros.svh"

module crlc_checker #(
	parameter int COUNT_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   last,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [COUNT_WIDTH-1:0] cpu_count,
	input logic                   malformed
);

	`CRLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cpu_count) && $stable(malformed), "Stalled result changed.")
	`CRLC_ASSERT_SAME(a_bad_zero, out_valid && malformed, cpu_count == '0, "Malformed list gave a nonzero count.")
	`CRLC_ASSERT_SAME(a_stall_cause, in_stall, out_stall, "Input stalled while the output was free.")
	`CRLC_ASSERT_NEXT(a_latency, in_valid && !in_stall && last ##1 !out_stall ##1 !out_stall, out_valid, "No result three cycles after the end of a list.")

endmodule

bind cpu_range_list_counter_top crlc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_crlc_checker (.*);

>>> tb/cpu_range_list_counter_top_test.sv
// Self-checking testbench of cpu_range_list_counter_top: list text in, member counts out.
// Uses crlc_pkg for the phase and character codes; needs nothing but the RTL.
// A short directed table runs first, then random lists under four idling mixes.
`timescale 1ns / 100ps

module cpu_range_list_counter_top_test;

	localparam int NUM_W = 16;
	localparam int CNT_W = 32;
	localparam int RANDOM_REQUESTS = 1050;
	localparam int DRAIN_CYCLES = 12;
	localparam longint CYCLE_LIMIT = 100000;
	localparam logic [7:0] EMPTY_MARK = "~";

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             bad;
	} tally_t;

	typedef struct packed {
		bit     known;
		tally_t value;
	} typed_tally_t;

	typedef struct {
		string        text;
		logic [7:0]   tail;
		bit           tail_has;
		typed_tally_t typed;
	} list_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       character = 8'h00;
	logic             has_character = 1'b0;
	logic             last = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [CNT_W-1:0] cpu_count;
	logic             malformed;

	cpu_range_list_counter_top #(
		.NUM_WIDTH(NUM_W),
		.COUNT_WIDTH(CNT_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.character(character),
		.has_character(has_character),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cpu_count(cpu_count),
		.malformed(malformed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Parser state of the predictor.
	crlc_pkg::phase_t pr_phase = crlc_pkg::PH_START;
	logic [NUM_W-1:0] pr_number = '0;
	logic [NUM_W-1:0] pr_range_start = '0;
	logic [CNT_W-1:0] pr_total = '0;
	bit               pr_bad = 1'b0;

	tally_t       expected_tallies[$];
	typed_tally_t typed_tallies[$];
	logic [8:0]   pending_bytes[$];
	list_row_t    directed_rows[$];

	int     idle_pct = 0;
	int     stall_pct = 0;
	int     errors = 0;
	int     results_checked = 0;
	int     accepted_requests = 0;
	int     sent_requests = 0;
	int     lists_sent = 0;
	longint cycles = 0;

	tally_t       predicted_tally;
	tally_t       wanted_tally;
	typed_tally_t list_typed;

	function void clear_list();
		pr_phase = crlc_pkg::PH_START;
		pr_number = '0;
		pr_range_start = '0;
		pr_total = '0;
		pr_bad = 1'b0;
	endfunction

	function void add_span(logic [NUM_W-1:0] first, logic [NUM_W-1:0] final_num);
		logic [CNT_W:0] sum;
		if (final_num < first) begin
			pr_bad = 1'b1;
		end else begin
			sum = {1'b0, pr_total} + {{(CNT_W + 1 - NUM_W){1'b0}}, final_num - first} + 1'b1;
			pr_total = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
		end
	endfunction

	function void add_digit(logic [3:0] d);
		logic [NUM_W+4:0] grown;
		grown = (NUM_W + 5)'(pr_number * 10 + d);
		if (grown > {NUM_W{1'b1}})
			pr_bad = 1'b1;
		else
			pr_number = grown[NUM_W-1:0];
	endfunction

	function void take_byte(logic [7:0] ch);
		bit         digit;
		logic [3:0] d;
		digit = (ch >= crlc_pkg::CH_ZERO) && (ch <= crlc_pkg::CH_NINE);
		d = 4'(ch - crlc_pkg::CH_ZERO);
		case (pr_phase)
			crlc_pkg::PH_START, crlc_pkg::PH_COMMA: begin
				if (digit) begin
					pr_number = NUM_W'(d);
					pr_phase = crlc_pkg::PH_FIRST;
				end else begin
					pr_bad = 1'b1;
				end
			end
			crlc_pkg::PH_DASH: begin
				if (digit) begin
					pr_number = NUM_W'(d);
					pr_phase = crlc_pkg::PH_LAST;
				end else begin
					pr_bad = 1'b1;
				end
			end
			crlc_pkg::PH_FIRST: begin
				if (digit) begin
					add_digit(d);
				end else if (ch == crlc_pkg::CH_DASH) begin
					pr_range_start = pr_number;
					pr_number = '0;
					pr_phase = crlc_pkg::PH_DASH;
				end else if (ch == crlc_pkg::CH_COMMA) begin
					add_span(pr_number, pr_number);
					pr_number = '0;
					pr_phase = crlc_pkg::PH_COMMA;
				end else begin
					pr_bad = 1'b1;
				end
			end
			crlc_pkg::PH_LAST: begin
				if (digit) begin
					add_digit(d);
				end else if (ch == crlc_pkg::CH_COMMA) begin
					add_span(pr_range_start, pr_number);
					pr_number = '0;
					pr_phase = crlc_pkg::PH_COMMA;
				end else begin
					pr_bad = 1'b1;
				end
			end
			default: pr_bad = 1'b1;
		endcase
	endfunction

	function bit predict_request(logic [7:0] ch, bit has, bit lst, output tally_t t);
		t = '0;
		if (has && !pr_bad)
			take_byte(ch);
		if (!lst)
			return 1'b0;
		if (!pr_bad) begin
			case (pr_phase)
				crlc_pkg::PH_START: ;
				crlc_pkg::PH_FIRST: add_span(pr_number, pr_number);
				crlc_pkg::PH_LAST:  add_span(pr_range_start, pr_number);
				default:  pr_bad = 1'b1;
			endcase
		end
		t.count = pr_bad ? '0 : pr_total;
		t.bad = pr_bad;
		clear_list();
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			accepted_requests++;
			if (predict_request(character, has_character, last, predicted_tally)) begin
				list_typed = (typed_tallies.size() != 0) ? typed_tallies.pop_front() : '0;
				expected_tallies.push_back(list_typed.known ? list_typed.value : predicted_tally);
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tallies.size() == 0) begin
				$display("%0t: unexpected result, cpu_count %0d malformed %0b",
					$time, cpu_count, malformed);
				errors++;
			end else begin
				wanted_tally = expected_tallies.pop_front();
				results_checked++;
				if (cpu_count !== wanted_tally.count) begin
					$display("%0t: cpu_count expected %0d, got %0d",
						$time, wanted_tally.count, cpu_count);
					errors++;
				end
				if (malformed !== wanted_tally.bad) begin
					$display("%0t: malformed expected %0b, got %0b",
						$time, wanted_tally.bad, malformed);
					errors++;
				end
			end
		end
	end

	task automatic send_request(logic [7:0] ch, bit has, bit lst);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		character <= ch;
		has_character <= has;
		last <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_list(typed_tally_t typed);
		bit final_one;
		for (int i = 0; i < pending_bytes.size(); i++) begin
			final_one = (i == pending_bytes.size() - 1);
			if (final_one)
				typed_tallies.push_back(typed);
			send_request(pending_bytes[i][7:0], pending_bytes[i][8], final_one);
			sent_requests++;
		end
		lists_sent++;
	endtask

	function void push_byte(logic [7:0] b);
		pending_bytes.push_back({1'b1, b});
	endfunction

	function void push_number(int unsigned n);
		string digits;
		digits = $sformatf("%0d", n);
		for (int i = 0; i < digits.len(); i++)
			push_byte(digits[i]);
	endfunction

	function int unsigned pick_number();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, 65535);
		if (r < 95)
			return $urandom_range(65500, 65535);
		return $urandom_range(65536, 99999);
	endfunction

	function void add_row(string text, logic [7:0] tail, bit tail_has, bit known,
		logic [CNT_W-1:0] count, bit bad);
		list_row_t row;
		row.text = text;
		row.tail = tail;
		row.tail_has = tail_has;
		row.typed.known = known;
		row.typed.value.count = count;
		row.typed.value.bad = bad;
		directed_rows.push_back(row);
	endfunction

	// Most lists are well formed with random content; about one in five is broken on purpose.
	function void build_random_list();
		int          fields;
		int unsigned lo;
		int unsigned hi;
		int          pos;
		pending_bytes.delete();
		fields = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
		if ($urandom_range(29) == 0)
			fields = 0;
		for (int f = 0; f < fields; f++) begin
			if (f != 0)
				push_byte(crlc_pkg::CH_COMMA);
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 3)) push_byte(crlc_pkg::CH_ZERO);
			lo = pick_number();
			push_number(lo);
			if ($urandom_range(1)) begin
				push_byte(crlc_pkg::CH_DASH);
				hi = ($urandom_range(9) == 0) ? pick_number() : lo + $urandom_range(0, 40);
				push_number(hi);
			end
		end
		if ($urandom_range(99) < 20) begin
			case ($urandom_range(3))
				0: begin
					pos = $urandom_range(pending_bytes.size());
					pending_bytes.insert(pos, {1'b1, 8'($urandom_range(0, 255))});
				end
				1: begin
					if (pending_bytes.size() != 0)
						pending_bytes.delete($urandom_range(pending_bytes.size() - 1));
				end
				2: push_byte($urandom_range(1) ? crlc_pkg::CH_COMMA : crlc_pkg::CH_DASH);
				default: begin
					if (pending_bytes.size() != 0) begin
						pos = $urandom_range(pending_bytes.size() - 1);
						pending_bytes.insert(pos, pending_bytes[pos]);
					end
				end
			endcase
		end
		if ($urandom_range(99) < 30) begin
			repeat ($urandom_range(1, 3)) begin
				pos = $urandom_range(pending_bytes.size());
				pending_bytes.insert(pos, {1'b0, 8'($urandom_range(0, 255))});
			end
		end
		if (pending_bytes.size() == 0 || $urandom_range(99) < 30)
			pending_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
	endfunction

	int idle_plan[4] = '{0, 62, 0, 8};
	int stall_plan[4] = '{0, 0, 62, 8};

	initial begin
		int target;

		// A tilde in the text stands for a request without a byte.
		add_row("", 8'h00, 1'b0, 1'b1, 0, 1'b0);
		add_row("", 8'h00, 1'b1, 1'b1, 0, 1'b1);
		add_row("0-6553", "5", 1'b1, 1'b1, 65536, 1'b0);
		add_row("6553", "6", 1'b1, 1'b1, 0, 1'b1);
		add_row("9-", "8", 1'b1, 1'b1, 0, 1'b1);
		add_row("1-1", "-", 1'b1, 1'b1, 0, 1'b1);
		add_row("", ",", 1'b1, 1'b1, 0, 1'b1);
		add_row("1", ",", 1'b1, 1'b1, 0, 1'b1);
		add_row("5", "-", 1'b1, 1'b1, 0, 1'b1);
		add_row("\377,", "1", 1'b1, 1'b1, 0, 1'b1);
		add_row("00~7", 8'h00, 1'b0, 1'b0, 0, 1'b0);
		add_row("3,1-", "2", 1'b1, 1'b0, 0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			pending_bytes.delete();
			for (int i = 0; i < directed_rows[r].text.len(); i++) begin
				if (directed_rows[r].text[i] == EMPTY_MARK)
					pending_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
				else
					push_byte(directed_rows[r].text[i]);
			end
			pending_bytes.push_back({directed_rows[r].tail_has, directed_rows[r].tail});
			send_list(directed_rows[r].typed);
		end

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_plan[p];
			stall_pct = stall_plan[p];
			target = sent_requests + RANDOM_REQUESTS / 4;
			while (sent_requests < target) begin
				build_random_list();
				send_list('0);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_tallies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_tallies.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_tallies.size());
			errors++;
		end

		$display("Sent %0d lists in %0d requests, directed edge cases first, then random text.",
			lists_sent, accepted_requests);
		$display("Checked %0d results under four idling mixes, %0d mismatches.",
			results_checked, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
